// ===== rtl/core/rtdt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtdt_pkg
// Shared widths, types and fixed-point constants for the RTD code to
// temperature datapath (resistance, deviation and PT100 polynomial).
// ----------------------------------------------------------------------------
package rtdt_pkg;

  // code and configuration widths
  localparam int CODE_BITS  = 15;
  localparam int BYTE_W     = 8;
  localparam int REF_W      = 13;
  localparam int NOM_W      = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REF_RES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NOM_RES = 1'd1;

  // configuration reset values
  localparam logic [REF_W-1:0] REF_RES_RST = 13'd430;
  localparam logic [NOM_W-1:0] NOM_RES_RST = 11'd100;

  // datapath widths
  localparam int RES_W  = 28;           // resistance, 15 fraction bits
  localparam int H_W    = 29;           // signed deviation from nominal
  localparam int POLY_W = 36;           // horner partial sums
  localparam int PROD_W = POLY_W + H_W; // full product of sum and deviation
  localparam int T_W    = 44;           // temperature before saturation
  localparam int CEL_W  = 19;
  localparam int KEL_W  = 19;

  typedef logic        [RES_W-1:0]  res_t;
  typedef logic signed [H_W-1:0]    h_t;
  typedef logic signed [POLY_W-1:0] poly_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [T_W-1:0]    temp_t;

  // binary points of the coefficients
  localparam int Q5 = 72;
  localparam int Q4 = 60;
  localparam int Q3 = 48;
  localparam int Q2 = 34;
  localparam int Q1 = 22;

  // rounded polynomial coefficients
  localparam poly_t COEF5 = 36'sd3456245983;
  localparam poly_t COEF4 = 36'sd796668760;
  localparam poly_t COEF3 = 36'sd205889657;
  localparam poly_t COEF2 = 36'sd16619125;
  localparam poly_t COEF1 = 36'sd10731786;

  // horner steps: four steps that add a coefficient, then the final product
  localparam int NSTEP = 5;

  localparam int SH4 = CODE_BITS + Q5 - Q4;
  localparam int SH3 = CODE_BITS + Q4 - Q3;
  localparam int SH2 = CODE_BITS + Q3 - Q2;
  localparam int SH1 = CODE_BITS + Q2 - Q1;

  localparam int STEP_SHIFT [NSTEP-1] = '{SH4, SH3, SH2, SH1};

  // coefficient placed above the shift plus the rounding half, in one add
  localparam prod_t STEP_K [NSTEP-1] = '{
    (prod_t'(COEF4) <<< SH4) + (prod_t'(1) <<< (SH4 - 1)),
    (prod_t'(COEF3) <<< SH3) + (prod_t'(1) <<< (SH3 - 1)),
    (prod_t'(COEF2) <<< SH2) + (prod_t'(1) <<< (SH2 - 1)),
    (prod_t'(COEF1) <<< SH1) + (prod_t'(1) <<< (SH1 - 1))
  };

  // saturation limits
  localparam temp_t CEL_MAX = temp_t'((64'sd1 <<< (CEL_W - 1)) - 64'sd1);
  localparam temp_t CEL_MIN = temp_t'(-(64'sd1 <<< (CEL_W - 1)));

endpackage

// ===== rtl/core/rtdt_poly.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtdt_poly
// Ten-stage horner pipeline: alternating multiply and round/add stages that
// turn the resistance deviation into a fixed-point Celsius value.
// ----------------------------------------------------------------------------
module rtdt_poly
  import rtdt_pkg::*;
#(
  parameter int TEMP_FRAC_BITS = 8
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  up_valid,
  output logic  up_stall,
  input  res_t  up_res,
  input  h_t    up_h,
  output logic  dn_valid,
  input  logic  dn_stall,
  output res_t  dn_res,
  output temp_t dn_temp
);

  localparam int NSTG        = 2 * NSTEP;
  localparam int FINAL_SHIFT = CODE_BITS + Q1 - TEMP_FRAC_BITS;
  localparam prod_t FINAL_K  = prod_t'(1) <<< (FINAL_SHIFT - 1);

  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;
  logic [NSTG-1:0] vld_in;
  logic [NSTG:0]   adv;

  res_t  res_r  [NSTG];
  h_t    h_r    [NSTG-2];
  prod_t prod_r [NSTEP];
  prod_t prod_nxt [NSTEP];
  poly_t p_r    [NSTEP-1];
  poly_t p_nxt  [NSTEP-1];
  temp_t t_r;
  temp_t t_nxt;

  poly_t mul_p   [NSTEP];
  h_t    mul_h   [NSTEP];
  prod_t rnd_sum [NSTEP-1];
  prod_t t_sum;

  // a stage moves when it is empty or the one after it moves
  assign adv[NSTG] = !dn_stall;
  for (genvar s = 0; s < NSTG; s++) begin : g_adv
    assign adv[s] = !vld_r[s] || adv[s+1];
  end

  assign vld_in = {vld_r[NSTG-2:0], up_valid};

  always_comb begin
    for (int s = 0; s < NSTG; s++) begin
      vld_nxt[s] = adv[s] ? vld_in[s] : vld_r[s];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // multiply operands: first step uses the top coefficient
  always_comb begin
    mul_p[0] = COEF5;
    mul_h[0] = up_h;
    for (int i = 1; i < NSTEP; i++) begin
      mul_p[i] = p_r[i-1];
      mul_h[i] = h_r[2*i-1];
    end
    for (int i = 0; i < NSTEP; i++) begin
      prod_nxt[i] = prod_t'(mul_p[i]) * prod_t'(mul_h[i]);
    end
  end

  // round to nearest and add the next coefficient in one add
  always_comb begin
    for (int i = 0; i < NSTEP - 1; i++) begin
      rnd_sum[i] = prod_r[i] + STEP_K[i];
      p_nxt[i]   = poly_t'(rnd_sum[i] >>> STEP_SHIFT[i]);
    end
    t_sum = prod_r[NSTEP-1] + FINAL_K;
    t_nxt = temp_t'(t_sum >>> FINAL_SHIFT);
  end

  // payload registers, loaded when their stage moves
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      res_r[0] <= up_res;
      h_r[0]   <= up_h;
    end
    for (int s = 1; s < NSTG; s++) begin
      if (adv[s]) begin
        res_r[s] <= res_r[s-1];
      end
    end
    for (int s = 1; s < NSTG - 2; s++) begin
      if (adv[s]) begin
        h_r[s] <= h_r[s-1];
      end
    end
    for (int i = 0; i < NSTEP; i++) begin
      if (adv[2*i]) begin
        prod_r[i] <= prod_nxt[i];
      end
    end
    for (int i = 0; i < NSTEP - 1; i++) begin
      if (adv[2*i+1]) begin
        p_r[i] <= p_nxt[i];
      end
    end
    if (adv[NSTG-1]) begin
      t_r <= t_nxt;
    end
  end

  assign up_stall = !adv[0];
  assign dn_valid = vld_r[NSTG-1];
  assign dn_res   = res_r[NSTG-1];
  assign dn_temp  = t_r;

endmodule

// ===== rtl/core/rtd_code_to_temperature_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtd_code_to_temperature_unit
// Converts a 15-bit RTD conversion code to resistance, Celsius and Kelvin.
// Pipeline: 2 front stages, 10 horner stages and 1 output register;
//   throughput one item per cycle while the output is not stalled.
// The throughput is set by the horner pipeline, one multiplier per step.
// Reset clears all valid bits; ref_resistance returns to 430, nominal to 100.
// ----------------------------------------------------------------------------
module rtd_code_to_temperature_unit
  import rtdt_pkg::*;
#(
  parameter int TEMP_FRAC_BITS = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [BYTE_W-1:0]       in_code_high_byte,
  input  logic [BYTE_W-1:0]       in_code_low_byte,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [RES_W-1:0]        out_resistance,
  output logic signed [CEL_W-1:0] out_celsius,
  output logic [KEL_W-1:0]        out_kelvin
);

  localparam longint KELVIN_OFS = ((longint'(27315) << TEMP_FRAC_BITS) + 50) / 100;
  localparam logic signed [T_W:0] KEL_OFS = (T_W+1)'(KELVIN_OFS);
  localparam logic signed [T_W:0] KEL_MAX = (T_W+1)'((64'sd1 <<< KEL_W) - 64'sd1);
  localparam logic signed [T_W:0] KEL_ZERO = '0;

  logic [REF_W-1:0] ref_res_r;
  logic [NOM_W-1:0] nom_res_r;

  logic [CODE_BITS-1:0] code;
  logic a_vld_r, a_vld_nxt;
  logic b_vld_r, b_vld_nxt;
  res_t a_res_r, a_res_nxt;
  res_t b_res_r;
  h_t   b_h_r, b_h_nxt;
  logic adv_a, adv_b, adv_o;

  logic  poly_up_stall;
  logic  poly_dn_valid;
  res_t  poly_res;
  temp_t poly_temp;

  logic signed [T_W:0]     kel_sum;
  logic                    out_valid_r, out_valid_nxt;
  res_t                    out_res_r;
  logic signed [CEL_W-1:0] out_cel_r, out_cel_nxt;
  logic [KEL_W-1:0]        out_kel_r, out_kel_nxt;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_res_r <= REF_RES_RST;
      nom_res_r <= NOM_RES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_REF_RES: ref_res_r <= cfg_wdata[REF_W-1:0];
        CFG_NOM_RES: nom_res_r <= cfg_wdata[NOM_W-1:0];
        default: ;
      endcase
    end
  end

  // stall chain from the output back to the input
  assign adv_o    = !out_valid_r || !out_stall;
  assign adv_b    = !b_vld_r || !poly_up_stall;
  assign adv_a    = !a_vld_r || adv_b;
  assign in_stall = !adv_a;

  // stage a: join bytes and scale by the reference resistor
  assign code      = {in_code_high_byte, in_code_low_byte[BYTE_W-1:1]};
  assign a_res_nxt = res_t'(code) * res_t'(ref_res_r);
  assign a_vld_nxt = adv_a ? in_valid : a_vld_r;

  // stage b: deviation from nominal resistance
  assign b_h_nxt   = h_t'({1'b0, a_res_r}) - h_t'({nom_res_r, {CODE_BITS{1'b0}}});
  assign b_vld_nxt = adv_b ? a_vld_r : b_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      a_vld_r <= a_vld_nxt;
      b_vld_r <= b_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a) begin
      a_res_r <= a_res_nxt;
    end
    if (adv_b) begin
      b_res_r <= a_res_r;
      b_h_r   <= b_h_nxt;
    end
  end

  // horner polynomial pipeline
  rtdt_poly #(
    .TEMP_FRAC_BITS (TEMP_FRAC_BITS)
  ) u_poly (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (b_vld_r),
    .up_stall (poly_up_stall),
    .up_res   (b_res_r),
    .up_h     (b_h_r),
    .dn_valid (poly_dn_valid),
    .dn_stall (!adv_o),
    .dn_res   (poly_res),
    .dn_temp  (poly_temp)
  );

  // kelvin offset and saturation of both temperatures
  always_comb begin
    kel_sum = (T_W+1)'(poly_temp) + KEL_OFS;
    if (poly_temp > CEL_MAX) begin
      out_cel_nxt = CEL_MAX[CEL_W-1:0];
    end else if (poly_temp < CEL_MIN) begin
      out_cel_nxt = CEL_MIN[CEL_W-1:0];
    end else begin
      out_cel_nxt = poly_temp[CEL_W-1:0];
    end
    if (kel_sum > KEL_MAX) begin
      out_kel_nxt = KEL_MAX[KEL_W-1:0];
    end else if (kel_sum < KEL_ZERO) begin
      out_kel_nxt = '0;
    end else begin
      out_kel_nxt = kel_sum[KEL_W-1:0];
    end
  end

  // output register
  assign out_valid_nxt = adv_o ? poly_dn_valid : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_o) begin
      out_res_r <= poly_res;
      out_cel_r <= out_cel_nxt;
      out_kel_r <= out_kel_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_resistance = out_res_r;
  assign out_celsius    = out_cel_r;
  assign out_kelvin     = out_kel_r;

  // input only stalls while the first stage holds an item
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> a_vld_r)
    else $error("input stalled with empty first stage");

  // a free output drains the whole pipeline, so the input must be open
  a_free_out_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while output is free");

  // a finished polynomial result reaches the output when not stalled
  a_poly_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (poly_dn_valid && !out_stall) |=> out_valid_r)
    else $error("polynomial result lost before output");

  // zero kelvin only arises from a negative celsius value
  a_kel_zero_cold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kel_r == '0) |-> out_cel_r[CEL_W-1])
    else $error("zero kelvin with non-negative celsius");

endmodule
